// ===== hdl/mms_pkg.sv =====
package mms_pkg;

    // Sizing of the mailbox.
    localparam int CLIENTS       = 8;
    localparam int SLOTS         = 8;
    localparam int PAYLOAD_BYTES = 8;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ISSUED_W  = $clog2(CLIENTS + 1);
    localparam int CIDX_W    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int PCOUNT_W  = $clog2(SLOTS + 1);

    localparam logic [63:0] PAYLOAD_MASK =
        (PAYLOAD_BYTES >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF
                             : ((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);

    // Request operations.
    typedef enum logic [1:0] {
        OP_JOIN    = 2'd0,
        OP_SEND    = 2'd1,
        OP_RECEIVE = 2'd2,
        OP_LEAVE   = 2'd3
    } op_t;

    // Status codes of a response.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_DEST      = 3'd1;
    localparam logic [2:0] ST_NO_SLOT       = 3'd2;
    localparam logic [2:0] ST_NO_MESSAGE    = 3'd3;
    localparam logic [2:0] ST_IDS_EXHAUSTED = 3'd4;

    typedef struct packed {
        op_t         operation;
        logic [3:0]  client;
        logic [3:0]  peer;
        logic [63:0] message_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  new_id;
        logic [63:0] message_out;
        logic [3:0]  pending;
    } out_item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t         op;
        logic        client_ok;
        logic        bad_dest;
        logic [3:0]  client;
        logic [3:0]  peer;
        logic [63:0] data;
    } cmd_t;

endpackage

// ===== hdl/mms_front.sv =====
module mms_front (
    input  logic              clk,
    input  logic              rst_n,
    input  mms_pkg::in_item_t request,
    input  logic              push,
    output logic              full,
    output mms_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  logic              cmd_take
);

    mms_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    mms_pkg::cmd_t classified;
    logic          do_push;
    logic          do_pop;

    // Classify the request: client range and destination checks.
    always_comb
    begin
        classified.op        = request.operation;
        classified.client    = request.client;
        classified.peer      = request.peer;
        classified.data      = request.message_in & mms_pkg::PAYLOAD_MASK;
        classified.client_ok = (request.client != 4'd0) &&
                               (int'(request.client) <= mms_pkg::CLIENTS);
        classified.bad_dest  = !classified.client_ok ||
                               (int'(request.peer) > mms_pkg::CLIENTS) ||
                               (request.peer == request.client);
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // Pointer and fill count of the command queue.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ===== hdl/mms_back.sv =====
module mms_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mms_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    output mms_pkg::out_item_t response,
    output logic               empty,
    input  logic               pop
);

    typedef enum logic {
        S_EXEC,
        S_REPORT
    } state_t;

    localparam int C = mms_pkg::CLIENTS;
    localparam int S = mms_pkg::SLOTS;

    state_t state_reg, state_next;

    // Slot file.
    logic                          valid_reg  [S];
    logic                          valid_next [S];
    logic [C-1:0]                  marks_reg  [S];
    logic [C-1:0]                  marks_next [S];
    logic [3:0]                    sender_reg [S];
    logic [3:0]                    target_reg [S];
    logic [63:0]                   payload_reg [S];
    logic [mms_pkg::SLOT_W-1:0]    last_reg, last_next;
    logic [mms_pkg::ISSUED_W-1:0]  issued_reg, issued_next;

    // Results of the execute step held for the report step.
    logic [2:0]  status_reg, status_next;
    logic [3:0]  nid_reg, nid_next;
    logic [63:0] msg_reg, msg_next;
    logic [3:0]  pc_reg, pc_next;

    // Response queue.
    mms_pkg::out_item_t rq_reg [2];
    logic               rq_wr_reg, rq_rd_reg;
    logic [1:0]         rq_count_reg;
    logic               rq_push, rq_pop;

    logic                       fill_en;
    logic [mms_pkg::SLOT_W-1:0] fill_idx;
    logic [C-1:0]               cbit;
    logic [C-1:0]               fill_marks;
    logic [mms_pkg::SLOT_W-1:0] start_idx, scan_idx, hit_idx;
    logic                       found;
    logic                       go;
    logic [mms_pkg::PCOUNT_W-1:0] pcount;
    logic                       pc_ok;
    logic [C-1:0]               pc_bit;

    assign go       = (state_reg == S_EXEC) && cmd_valid && (rq_count_reg != 2'd2);
    assign cmd_take = go;

    // Execute one command against the slot file.
    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        issued_next = issued_reg;
        status_next = status_reg;
        nid_next    = nid_reg;
        msg_next    = msg_reg;
        pc_next     = pc_reg;
        fill_en     = 1'b0;
        fill_idx    = '0;
        found       = 1'b0;
        hit_idx     = '0;
        scan_idx    = '0;
        cbit        = '0;
        fill_marks  = '0;
        start_idx   = '0;
        for (int s = 0; s < S; s++)
        begin
            valid_next[s] = valid_reg[s];
            marks_next[s] = marks_reg[s];
        end
        if (cmd.client_ok)
        begin
            cbit[mms_pkg::CIDX_W'(cmd.client - 4'd1)] = 1'b1;
        end
        for (int i = 0; i < C; i++)
        begin
            fill_marks[i] = (i >= int'(issued_reg)) || cbit[i];
        end
        if (state_reg == S_REPORT)
        begin
            state_next = S_EXEC;
        end
        else if (go)
        begin
            state_next  = S_REPORT;
            status_next = mms_pkg::ST_OK;
            nid_next    = 4'd0;
            msg_next    = 64'd0;
            pc_next     = cmd.client;
            unique case (cmd.op)
                mms_pkg::OP_JOIN:
                begin
                    if (int'(issued_reg) < C)
                    begin
                        issued_next = issued_reg + 1'b1;
                        nid_next    = 4'(issued_reg + 1'b1);
                        pc_next     = 4'(issued_reg + 1'b1);
                    end
                    else
                    begin
                        status_next = mms_pkg::ST_IDS_EXHAUSTED;
                    end
                end
                mms_pkg::OP_SEND:
                begin
                    if (cmd.bad_dest)
                    begin
                        status_next = mms_pkg::ST_BAD_DEST;
                    end
                    else if (cmd.peer == 4'd0)
                    begin
                        if (valid_reg[0])
                        begin
                            status_next = mms_pkg::ST_NO_SLOT;
                        end
                        else
                        begin
                            fill_en  = 1'b1;
                            fill_idx = '0;
                        end
                    end
                    else
                    begin
                        // Round-robin search over the point-to-point slots.
                        start_idx = (int'(last_reg) >= S - 1) ? mms_pkg::SLOT_W'(1)
                                                             : last_reg + 1'b1;
                        scan_idx  = start_idx;
                        for (int k = 0; k < S - 1; k++)
                        begin
                            if (!found && !valid_reg[scan_idx])
                            begin
                                found   = 1'b1;
                                hit_idx = scan_idx;
                            end
                            scan_idx = (int'(scan_idx) == S - 1) ? mms_pkg::SLOT_W'(1)
                                                                : scan_idx + 1'b1;
                        end
                        if (found)
                        begin
                            fill_en   = 1'b1;
                            fill_idx  = hit_idx;
                            last_next = hit_idx;
                        end
                        else
                        begin
                            status_next = mms_pkg::ST_NO_SLOT;
                        end
                    end
                end
                mms_pkg::OP_RECEIVE:
                begin
                    if (!cmd.client_ok)
                    begin
                        status_next = mms_pkg::ST_BAD_DEST;
                    end
                    else
                    begin
                        // First slot from this sender, unread, meant for us.
                        for (int s = 0; s < S; s++)
                        begin
                            if (!found && valid_reg[s] && ((marks_reg[s] & cbit) == '0) &&
                                (sender_reg[s] == cmd.peer) &&
                                ((target_reg[s] == 4'd0) || (target_reg[s] == cmd.client)))
                            begin
                                found   = 1'b1;
                                hit_idx = mms_pkg::SLOT_W'(s);
                            end
                        end
                        if (found)
                        begin
                            msg_next = payload_reg[hit_idx];
                            if (target_reg[hit_idx] == 4'd0)
                            begin
                                marks_next[hit_idx] = marks_reg[hit_idx] | cbit;
                                if (&(marks_reg[hit_idx] | cbit))
                                begin
                                    valid_next[hit_idx] = 1'b0;
                                end
                            end
                            else
                            begin
                                valid_next[hit_idx] = 1'b0;
                            end
                        end
                        else
                        begin
                            status_next = mms_pkg::ST_NO_MESSAGE;
                        end
                    end
                end
                mms_pkg::OP_LEAVE:
                begin
                    if (cmd.client_ok)
                    begin
                        if (valid_reg[0])
                        begin
                            marks_next[0] = marks_reg[0] | cbit;
                        end
                        for (int s = 1; s < S; s++)
                        begin
                            if (valid_reg[s] && (target_reg[s] == cmd.client))
                            begin
                                valid_next[s] = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    status_next = mms_pkg::ST_OK;
                end
            endcase
            if (fill_en)
            begin
                valid_next[fill_idx] = 1'b1;
                marks_next[fill_idx] = fill_marks;
            end
        end
    end

    // Pending count for the reported client, taken from the updated slot file.
    always_comb
    begin
        pcount = '0;
        pc_bit = '0;
        pc_ok  = (pc_reg != 4'd0) && (int'(pc_reg) <= C);
        if (pc_ok)
        begin
            pc_bit[mms_pkg::CIDX_W'(pc_reg - 4'd1)] = 1'b1;
            if (valid_reg[0] && ((marks_reg[0] & pc_bit) == '0) &&
                (sender_reg[0] != pc_reg))
            begin
                pcount = pcount + 1'b1;
            end
            for (int s = 1; s < S; s++)
            begin
                if (valid_reg[s] && (target_reg[s] == pc_reg))
                begin
                    pcount = pcount + 1'b1;
                end
            end
        end
    end

    assign rq_push  = (state_reg == S_REPORT);
    assign rq_pop   = pop && !empty;
    assign empty    = (rq_count_reg == 2'd0);
    assign response = rq_reg[rq_rd_reg];

    // State, slot status and response queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_EXEC;
            last_reg     <= '0;
            issued_reg   <= '0;
            rq_wr_reg    <= 1'b0;
            rq_rd_reg    <= 1'b0;
            rq_count_reg <= 2'd0;
            for (int s = 0; s < S; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            issued_reg   <= issued_next;
            rq_wr_reg    <= rq_wr_reg ^ rq_push;
            rq_rd_reg    <= rq_rd_reg ^ rq_pop;
            rq_count_reg <= rq_count_reg + {1'b0, rq_push} - {1'b0, rq_pop};
            for (int s = 0; s < S; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
        end
    end

    // Slot contents and step results need no reset.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        nid_reg    <= nid_next;
        msg_reg    <= msg_next;
        pc_reg     <= pc_next;
        for (int s = 0; s < S; s++)
        begin
            marks_reg[s] <= marks_next[s];
        end
        if (fill_en)
        begin
            sender_reg[fill_idx]  <= cmd.client;
            target_reg[fill_idx]  <= cmd.peer;
            payload_reg[fill_idx] <= cmd.data;
        end
        if (rq_push)
        begin
            rq_reg[rq_wr_reg].status      <= status_reg;
            rq_reg[rq_wr_reg].new_id      <= nid_reg;
            rq_reg[rq_wr_reg].message_out <= msg_reg;
            rq_reg[rq_wr_reg].pending     <= 4'(pcount);
        end
    end

endmodule

// ===== hdl/message_mailbox_slots.sv =====
// Mailbox shared by up to eight clients, with one broadcast slot and
// point-to-point slots.
// Requests enter through a queue port: a transfer happens at a rising edge
// with push high and full low. Each request (join, send, receive, leave)
// yields exactly one response, read from a queue port: the oldest response
// is shown while empty is low and is transferred at an edge with pop high.
// A request passes through the command queue and then the execute step
// and the report step of the slot file controller, which computes the
// pending count from the updated slots, before its response is queued.
// The controller takes no new command until the report step is done.
// A two-entry command queue sits in front of the controller and a two-entry
// response queue behind it, so requests keep being taken while a response
// waits; when pop stays low both queues fill and full rises.
// Reset empties all slots, both queues, the issued id count and the
// round-robin pointer.
module message_mailbox_slots (
    input  logic               clk,
    input  logic               rst_n,
    input  mms_pkg::in_item_t  request,
    input  logic               push,
    output logic               full,
    output mms_pkg::out_item_t response,
    output logic               empty,
    input  logic               pop
);

    mms_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_take;

    // Request acceptance and classification.
    mms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    // Slot file controller and response queue.
    mms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .response  (response),
        .empty     (empty),
        .pop       (pop)
    );

`ifndef NO_ASSERTIONS
    // An issued id only comes with a successful join.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && response.new_id != 4'd0) |-> (response.status == mms_pkg::ST_OK))
    else $error("new id reported with a failing status");

    // A delivered payload only comes with a successful step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && response.message_out != 64'd0) |-> (response.status == mms_pkg::ST_OK))
    else $error("payload reported with a failing status");

    // The controller never takes a command the queue does not hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
    else $error("command taken from an empty queue");

    // Commands are never taken back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !cmd_take)
    else $error("commands taken back to back");
`endif

endmodule
